// ----- rtl/mcpid_pkg.sv -----
package mcpid_pkg;

	// Q16.16 saturation bounds.
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// Register reset values, unsigned Q16.16.
	localparam logic [31:0] GEAR_RATIO_RESET    = 32'd65536;
	localparam logic [31:0] POSITION_GAIN_RESET = 32'd3276800;
	localparam logic [31:0] VELOCITY_GAIN_RESET = 32'd1638;
	localparam logic [31:0] INTEGRAL_GAIN_RESET = 32'd3277;

	// Torque division: a 32-bit magnitude shifted up by 16 gives a 48-bit dividend.
	localparam int DIV_WIDTH = 48;
	localparam int DIV_CNT_W = 6;

	// Command codes.
	localparam logic CMD_SETPOINT = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	// Positions of the invalid marks.
	localparam int MARK_POSITION = 0;
	localparam int MARK_VELOCITY = 1;
	localparam int MARK_TORQUE   = 2;

	typedef enum logic [1:0] {
		MODE_KEEP     = 2'd0,
		MODE_TORQUE   = 2'd1,
		MODE_VELOCITY = 2'd2,
		MODE_POSITION = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_GEAR_RATIO    = 2'd0,
		REG_POSITION_GAIN = 2'd1,
		REG_VELOCITY_GAIN = 2'd2,
		REG_INTEGRAL_GAIN = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SP_MP,
		S_SP_MV,
		S_SP_WV,
		S_DIV,
		S_DIV_END,
		S_T_VE,
		S_T_PE,
		S_V_MUL,
		S_V_ADD,
		S_P_MI,
		S_P_MP,
		S_P_MD,
		S_P_AD,
		S_P_AI,
		S_RES
	} state_t;

	typedef struct packed {
		logic               command;
		logic [1:0]         mode_request;
		logic signed [31:0] position_setpoint;
		logic signed [31:0] velocity_setpoint;
		logic signed [31:0] torque_setpoint;
		logic [2:0]         setpoint_bad;
		logic signed [31:0] position_estimate;
		logic signed [31:0] velocity_estimate;
		logic signed [31:0] present_drive;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] drive_value;
		logic               drive_updated;
	} drive_item_t;

endpackage

// ----- rtl/multimode_motor_pid_controller_top.sv -----
// Multimode motor controller (torque, velocity, position PID) in signed Q16.16.
// A setpoint item keeps the input stalled through two gear-ratio products on the
// shared multiplier and a 48-step restoring divider for the torque setpoint; it gives
// no result. A tick item goes straight to its result in torque mode or with a needed
// setpoint marked invalid; in velocity and position mode the sequencer steps it through
// the single shared multiplier and saturating adder. The input stays stalled until the
// result has entered the output register, which may wait for that register to free up.
// Each tick gives one result. The block takes no item while one is in work; a finished
// result waits in an output register so the next item can enter. Configuration writes
// are always ready and take effect at once; a write of zero to the gear ratio is ignored.
module multimode_motor_pid_controller_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  mcpid_pkg::cmd_item_t     cmd_item,
	output logic                     drive_valid,
	input  logic                     drive_stall,
	output mcpid_pkg::drive_item_t   drive_item,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  mcpid_pkg::cfg_reg_t      cfg_index,
	input  logic [31:0]              cfg_data
);
	import mcpid_pkg::*;

	state_t state_q, state_d;

	// Configuration registers.
	logic [31:0] gear_q, kp_q, kd_q, ki_q;

	// Controller state.
	mode_t              mode_q;
	logic signed [31:0] gp_q, gv_q, gt_q, integ_q;
	logic [2:0]         marks_q;

	// Working registers.
	cmd_item_t          item_q;
	logic signed [31:0] perr_q, verr_q, acc_q;
	logic               upd_q;
	logic signed [63:0] prod_q;
	logic [31:0]        rem_q;
	logic [DIV_WIDTH-1:0] dvd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic               neg_q;

	// Output register.
	logic        out_valid_q;
	drive_item_t out_q;

	logic               accept;
	logic               out_free;
	logic [2:0]         need;
	logic               blocked;
	logic signed [31:0] mul_a;
	logic [31:0]        mul_g;
	logic signed [63:0] mul_full;
	logic signed [31:0] prod_sat;
	logic signed [31:0] add_a, add_b;
	logic               add_sub;
	logic signed [32:0] sum_full;
	logic signed [31:0] sum_sat;
	logic [32:0]        trial;
	logic [32:0]        trial_diff;
	logic               trial_ge;
	logic [31:0]        torque_mag;
	logic signed [31:0] div_sat;

	assign cfg_ready   = 1'b1;
	assign cmd_stall   = (state_q != S_IDLE);
	assign accept      = cmd_valid && !cmd_stall;
	assign out_free    = !out_valid_q || !drive_stall;
	assign drive_valid = out_valid_q;
	assign drive_item  = out_q;

	// Marks that the active mode needs to be clear.
	always_comb begin
		unique case (mode_q)
			MODE_POSITION: need = 3'b111;
			MODE_VELOCITY: need = 3'b110;
			default:       need = 3'b100;
		endcase
	end
	assign blocked = |(marks_q & need);

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_g = '0;
		unique case (state_q)
			S_SP_MP: begin
				mul_a = item_q.position_setpoint;
				mul_g = gear_q;
			end
			S_SP_MV: begin
				mul_a = item_q.velocity_setpoint;
				mul_g = gear_q;
			end
			S_V_MUL: begin
				mul_a = verr_q;
				mul_g = kp_q;
			end
			S_P_MI: begin
				mul_a = perr_q;
				mul_g = ki_q;
			end
			S_P_MP: begin
				mul_a = perr_q;
				mul_g = kp_q;
			end
			S_P_MD: begin
				mul_a = verr_q;
				mul_g = kd_q;
			end
			default: begin
				mul_a = '0;
				mul_g = '0;
			end
		endcase
	end

	// Signed times unsigned; the product always fits in 64 bits.
	assign mul_full = mul_a * $signed({1'b0, mul_g});

	// Floor shift by 16 is a bit-select of the product, then saturate to 32 bits.
	always_comb begin
		if ((prod_q[63:47] == '0) || (prod_q[63:47] == '1)) begin
			prod_sat = prod_q[47:16];
		end else begin
			prod_sat = prod_q[63] ? Q_MIN : Q_MAX;
		end
	end

	// Shared saturating adder operand selection.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_T_VE: begin
				add_a   = gv_q;
				add_b   = item_q.velocity_estimate;
				add_sub = 1'b1;
			end
			S_T_PE: begin
				add_a   = gp_q;
				add_b   = item_q.position_estimate;
				add_sub = 1'b1;
			end
			S_V_ADD, S_P_MD: begin
				add_a = gt_q;
				add_b = prod_sat;
			end
			S_P_MP: begin
				add_a = integ_q;
				add_b = prod_sat;
			end
			S_P_AD: begin
				add_a = acc_q;
				add_b = prod_sat;
			end
			S_P_AI: begin
				add_a = acc_q;
				add_b = integ_q;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign sum_full = add_sub ? ({add_a[31], add_a} - {add_b[31], add_b})
	                          : ({add_a[31], add_a} + {add_b[31], add_b});

	always_comb begin
		if (sum_full[32] != sum_full[31]) begin
			sum_sat = sum_full[32] ? Q_MIN : Q_MAX;
		end else begin
			sum_sat = sum_full[31:0];
		end
	end

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	assign trial      = {rem_q, dvd_q[DIV_WIDTH-1]};
	assign trial_ge   = (trial >= {1'b0, gear_q});
	assign trial_diff = trial - {1'b0, gear_q};

	assign torque_mag = item_q.torque_setpoint[31] ? (~item_q.torque_setpoint + 32'd1)
	                                               : item_q.torque_setpoint;

	// Signed, saturated quotient once the division is done.
	always_comb begin
		if (neg_q) begin
			if (dvd_q > DIV_WIDTH'(64'd2147483648)) begin
				div_sat = Q_MIN;
			end else begin
				div_sat = ~dvd_q[31:0] + 32'd1;
			end
		end else begin
			if (dvd_q > DIV_WIDTH'(64'd2147483647)) begin
				div_sat = Q_MAX;
			end else begin
				div_sat = dvd_q[31:0];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd_item.command == CMD_SETPOINT) begin
						state_d = S_SP_MP;
					end else if (blocked || (mode_q != MODE_VELOCITY && mode_q != MODE_POSITION)) begin
						state_d = S_RES;
					end else begin
						state_d = S_T_VE;
					end
				end
			end
			S_SP_MP:   state_d = S_SP_MV;
			S_SP_MV:   state_d = S_SP_WV;
			S_SP_WV:   state_d = S_DIV;
			S_DIV:     state_d = (cnt_q == '0) ? S_DIV_END : S_DIV;
			S_DIV_END: state_d = S_IDLE;
			S_T_VE:    state_d = (mode_q == MODE_POSITION) ? S_T_PE : S_V_MUL;
			S_T_PE:    state_d = S_P_MI;
			S_V_MUL:   state_d = S_V_ADD;
			S_V_ADD:   state_d = S_RES;
			S_P_MI:    state_d = S_P_MP;
			S_P_MP:    state_d = S_P_MD;
			S_P_MD:    state_d = S_P_AD;
			S_P_AD:    state_d = S_P_AI;
			S_P_AI:    state_d = S_RES;
			S_RES:     state_d = out_free ? S_IDLE : S_RES;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; a zero gear ratio is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q <= GEAR_RATIO_RESET;
			kp_q   <= POSITION_GAIN_RESET;
			kd_q   <= VELOCITY_GAIN_RESET;
			ki_q   <= INTEGRAL_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GEAR_RATIO: begin
					if (cfg_data != '0) begin
						gear_q <= cfg_data;
					end
				end
				REG_POSITION_GAIN: kp_q <= cfg_data;
				REG_VELOCITY_GAIN: kd_q <= cfg_data;
				REG_INTEGRAL_GAIN: ki_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Controller state: targets, marks, mode and the integral.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TORQUE;
			gp_q    <= '0;
			gv_q    <= '0;
			gt_q    <= '0;
			integ_q <= '0;
			marks_q <= '0;
		end else begin
			unique case (state_q)
				S_SP_MV: gp_q <= prod_sat;
				S_SP_WV: gv_q <= prod_sat;
				S_DIV_END: begin
					gt_q    <= div_sat;
					marks_q <= item_q.setpoint_bad;
					if (mode_t'(item_q.mode_request) != MODE_KEEP) begin
						mode_q <= mode_t'(item_q.mode_request);
					end
				end
				S_P_MP: integ_q <= sum_sat;
				default: ;
			endcase
		end
	end

	// Working registers of the sequencer and the divider.
	always_ff @(posedge clk) begin
		prod_q <= mul_full;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= cmd_item;
					if (blocked) begin
						acc_q <= cmd_item.present_drive;
						upd_q <= 1'b0;
					end else begin
						acc_q <= gt_q;
						upd_q <= 1'b1;
					end
				end
			end
			S_SP_WV: begin
				neg_q <= item_q.torque_setpoint[31];
				dvd_q <= {torque_mag, 16'd0};
				rem_q <= '0;
				cnt_q <= DIV_CNT_W'(DIV_WIDTH - 1);
			end
			S_DIV: begin
				rem_q <= trial_ge ? trial_diff[31:0] : trial[31:0];
				dvd_q <= {dvd_q[DIV_WIDTH-2:0], trial_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			S_T_VE: verr_q <= sum_sat;
			S_T_PE: perr_q <= sum_sat;
			S_V_ADD, S_P_MD, S_P_AD, S_P_AI: begin
				acc_q <= sum_sat;
				upd_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// Output register: loads the finished result, clears when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RES && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			out_q.drive_value   <= acc_q;
			out_q.drive_updated <= upd_q;
		end
	end

endmodule
